FILE: sv/ballistic_launch_angle_solver_assert.svh
// Assertion macros shared by the launch angle solver RTL.
`ifndef BALLISTIC_LAUNCH_ANGLE_SOLVER_ASSERT_SVH
`define BALLISTIC_LAUNCH_ANGLE_SOLVER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define BLAS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("launch angle solver assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define BLAS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("launch angle solver assertion failed");
`else
`define BLAS_ASSERT_IMP(lbl, ante, cons)
`define BLAS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: sv/blas_pkg.sv
// Shared constants, types and helpers of the launch angle solver.
`timescale 1ns / 1ps
`default_nettype none

package blas_pkg;

    // Register indexes of the configuration port
    localparam logic [0:0] REG_GRAVITY_X = 1'b0;
    localparam logic [0:0] REG_GRAVITY_Y = 1'b1;

    // Fixed widths of the quadratic and angle datapaths
    localparam int FIT_BITS      = 30;
    localparam int SQ_W          = 2 * FIT_BITS;
    localparam int DW            = 62;
    localparam int RW            = 63;
    localparam int ISQ_STAGES    = 32;
    localparam int CORDIC_ITERS  = 30;
    localparam int CORDIC_NORM   = 59;
    localparam int CORDIC_STAGES = 3 + CORDIC_ITERS;
    localparam int XW            = 63;
    localparam int ZW            = 36;
    localparam int AW            = 38;

    localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sd6746518852;

    localparam logic [29:0] ATAN_TAB [CORDIC_ITERS] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
        30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
        30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535,
        30'd32767, 30'd16383, 30'd8191, 30'd4095, 30'd2047,
        30'd1023, 30'd511, 30'd255, 30'd127, 30'd63,
        30'd31, 30'd15, 30'd7, 30'd3, 30'd1
    };

    // Flags and operands that ride along the square root and angle stages
    typedef struct packed {
        logic [FIT_BITS-1:0] p;
        logic [FIT_BITS-1:0] c;
        logic                cneg;
        logic                deg;
        logic                kill;
        logic                tang;
    } side_t;

    // Position of the highest set bit plus one, zero for zero
    function automatic logic [7:0] bit_len(input logic [127:0] v);
        logic [7:0] n;
        n = '0;
        for (int i = 0; i < 128; i++) begin
            if (v[i] && ((v >> (i + 1)) == 128'd0)) begin
                n = 8'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: sv/blas_isqrt.sv
// Pipelined integer floor square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module blas_isqrt (
    input  logic                      clk,
    input  logic                      en,
    input  logic [blas_pkg::DW-1:0]   d_in,
    output logic [31:0]               r_out
);

    localparam int RW = blas_pkg::RW;
    localparam int N  = blas_pkg::ISQ_STAGES;

    logic [RW-1:0] v_reg [N];
    logic [RW-1:0] r_reg [N];

    for (genvar j = 0; j < N; j++) begin : g_step
        localparam logic [RW-1:0] BIT_V = RW'(1) << (62 - 2 * j);
        logic [RW-1:0] v_prev;
        logic [RW-1:0] r_prev;
        logic [RW-1:0] trial;

        if (j == 0) begin : g_first
            assign v_prev = RW'(d_in);
            assign r_prev = '0;
        end else begin : g_next
            assign v_prev = v_reg[j-1];
            assign r_prev = r_reg[j-1];
        end

        assign trial = r_prev + BIT_V;

        // Subtract the trial value when it fits, shift the root
        always_ff @(posedge clk) begin
            if (en) begin
                if (v_prev >= trial) begin
                    v_reg[j] <= v_prev - trial;
                    r_reg[j] <= (r_prev >> 1) + BIT_V;
                end else begin
                    v_reg[j] <= v_prev;
                    r_reg[j] <= r_prev >> 1;
                end
            end
        end
    end

    assign r_out = r_reg[N-1][31:0];

endmodule

`default_nettype wire

FILE: sv/blas_cordic.sv
// Pipelined vectoring CORDIC giving atan2 in Q30 radians.
`timescale 1ns / 1ps
`default_nettype none

module blas_cordic #(
    parameter int IN_W = 33
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [IN_W-1:0]           x_in,
    input  logic signed [IN_W-1:0]           y_in,
    output logic signed [blas_pkg::ZW-1:0]   z_out
);

    localparam int EW = IN_W + 1;
    localparam int XW = blas_pkg::XW;
    localparam int ZW = blas_pkg::ZW;
    localparam int N  = blas_pkg::CORDIC_ITERS;

    logic signed [EW-1:0] xe;
    logic signed [EW-1:0] ye;
    logic signed [EW-1:0] xa_next;
    logic signed [EW-1:0] ya_next;
    logic signed [EW-1:0] ymag;
    logic signed [ZW-1:0] base_next;
    logic [EW-1:0]        or_next;

    logic signed [EW-1:0] xa0_reg, ya0_reg, xa1_reg, ya1_reg;
    logic signed [ZW-1:0] base0_reg, base1_reg;
    logic                 zero0_reg, zero1_reg;
    logic [EW-1:0]        or0_reg;
    logic [5:0]           sh1_reg;
    logic [7:0]           len1;
    logic [7:0]           sh_next;

    logic signed [XW-1:0] ix_reg [N+1];
    logic signed [XW-1:0] iy_reg [N+1];
    logic signed [ZW-1:0] iz_reg [N+1];
    logic                 izero_reg [N+1];

    // Turn a left half-plane vector by pi
    always_comb begin
        xe = EW'(x_in);
        ye = EW'(y_in);
        if (x_in < 0) begin
            xa_next   = -xe;
            ya_next   = -ye;
            base_next = (y_in >= 0) ? blas_pkg::PI_Q30 : -blas_pkg::PI_Q30;
        end else begin
            xa_next   = xe;
            ya_next   = ye;
            base_next = '0;
        end
        ymag    = (ya_next < 0) ? -ya_next : ya_next;
        or_next = $unsigned(xa_next) | $unsigned(ymag);
    end

    always_ff @(posedge clk) begin
        if (en) begin
            xa0_reg   <= xa_next;
            ya0_reg   <= ya_next;
            base0_reg <= base_next;
            zero0_reg <= (x_in == 0) && (y_in == 0);
            or0_reg   <= or_next;
        end
    end

    // Find the shift that brings the larger magnitude to the working size
    assign len1    = blas_pkg::bit_len(128'(or0_reg));
    assign sh_next = 8'(blas_pkg::CORDIC_NORM) - len1;

    always_ff @(posedge clk) begin
        if (en) begin
            xa1_reg   <= xa0_reg;
            ya1_reg   <= ya0_reg;
            base1_reg <= base0_reg;
            zero1_reg <= zero0_reg;
            sh1_reg   <= sh_next[5:0];
        end
    end

    // Normalize and seed the angle accumulator with the half-plane turn
    always_ff @(posedge clk) begin
        if (en) begin
            ix_reg[0]    <= XW'(xa1_reg) <<< sh1_reg;
            iy_reg[0]    <= XW'(ya1_reg) <<< sh1_reg;
            iz_reg[0]    <= base1_reg;
            izero_reg[0] <= zero1_reg;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        localparam logic signed [ZW-1:0] ATAN_Z = ZW'(blas_pkg::ATAN_TAB[i]);
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;

        assign dx = iy_reg[i] >>> i;
        assign dy = ix_reg[i] >>> i;

        // Rotate toward the x axis
        always_ff @(posedge clk) begin
            if (en) begin
                if (iy_reg[i] > 0) begin
                    ix_reg[i+1] <= ix_reg[i] + dx;
                    iy_reg[i+1] <= iy_reg[i] - dy;
                    iz_reg[i+1] <= iz_reg[i] + ATAN_Z;
                end else begin
                    ix_reg[i+1] <= ix_reg[i] - dx;
                    iy_reg[i+1] <= iy_reg[i] + dy;
                    iz_reg[i+1] <= iz_reg[i] - ATAN_Z;
                end
                izero_reg[i+1] <= izero_reg[i];
            end
        end
    end

    // A zero vector gives angle zero
    assign z_out = izero_reg[N] ? '0 : iz_reg[N];

endmodule

`default_nettype wire

FILE: sv/ballistic_launch_angle_solver.sv
// Launch angle solver top level: gravity registers, quadratic, sqrt and angle pipeline.
// Depth: 76 register stages, every stage registered and enabled together.
// Throughput: one beat per cycle while the output skid register is empty.
// An output skid register catches one result when out_ready drops; in_ready stays low
// while it holds that result.
// Reset: rst_n clears valid bits and skid state at once; gravity_x and gravity_y read 1.0.
`timescale 1ns / 1ps
`default_nettype none
`include "ballistic_launch_angle_solver_assert.svh"

module ballistic_launch_angle_solver #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [0:0]                    cfg_index,
    input  logic [WORD_WIDTH-1:0]         cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [WORD_WIDTH-1:0]  source_x,
    input  logic signed [WORD_WIDTH-1:0]  source_y,
    input  logic signed [WORD_WIDTH-1:0]  target_x,
    input  logic signed [WORD_WIDTH-1:0]  target_y,
    input  logic [WORD_WIDTH-2:0]         launch_speed,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    solution_count,
    output logic signed [FRAC_BITS+3:0]   angle_first,
    output logic signed [FRAC_BITS+3:0]   angle_second,
    output logic                          degenerate
);

    localparam int W      = WORD_WIDTH;
    localparam int NW     = W + 1;
    localparam int PW     = 2 * W + 1;
    localparam int SW     = 2 * W - 2;
    localparam int CTW    = 2 * W + 2;
    localparam int MAGW   = 2 * W + 1;
    localparam int ANG_W  = FRAC_BITS + 4;
    localparam int FIT    = blas_pkg::FIT_BITS;
    localparam int SQW    = blas_pkg::SQ_W;
    localparam int AW     = blas_pkg::AW;
    localparam int CIN_W  = (W > 33) ? W : 33;
    localparam int ISQ_N  = blas_pkg::ISQ_STAGES;
    localparam int COR_N  = blas_pkg::CORDIC_STAGES;
    localparam int SIDE_N = ISQ_N + 1 + COR_N;
    localparam int NS     = 8 + SIDE_N + 2;
    localparam int RS     = 30 - FRAC_BITS;

    localparam logic signed [AW-1:0] HALF_RND = AW'(1) << (RS - 1);
    localparam logic signed [AW-1:0] ANG_LIM  =
        (AW'(blas_pkg::TWO_PI_Q30) + HALF_RND) >>> RS;
    localparam logic signed [AW-1:0] OFF_POS  =
        AW'(blas_pkg::PI_Q30) - AW'(blas_pkg::HALF_PI_Q30);
    localparam logic signed [AW-1:0] OFF_NEG  = -AW'(blas_pkg::HALF_PI_Q30);

    logic signed [W-1:0] gx_reg, gy_reg;
    logic [NS-1:0]       v_reg;
    logic                adv;

    // Gravity registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            gx_reg <= W'(1) << FRAC_BITS;
            gy_reg <= W'(1) << FRAC_BITS;
        end else if (cfg_write) begin
            case (cfg_index)
                blas_pkg::REG_GRAVITY_X: gx_reg <= cfg_data;
                blas_pkg::REG_GRAVITY_Y: gy_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits advance with the data while the skid register is free
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    // Stage 0: offset from source to target
    logic signed [NW-1:0] nx_reg, ny_reg;
    logic [W-2:0]         spd_reg;

    always_ff @(posedge clk) begin
        if (adv) begin
            nx_reg  <= NW'(target_x) - NW'(source_x);
            ny_reg  <= NW'(target_y) - NW'(source_y);
            spd_reg <= launch_speed;
        end
    end

    // Stage 1: rotation products and speed squared
    logic signed [PW-1:0] gynx_next, gxny_next, gxnx_next, gyny_next;
    logic signed [PW-1:0] gynx_reg, gxny_reg, gxnx_reg, gyny_reg;
    logic [SW-1:0]        psq_next, psq_reg;

    assign gynx_next = gy_reg * nx_reg;
    assign gxny_next = gx_reg * ny_reg;
    assign gxnx_next = gx_reg * nx_reg;
    assign gyny_next = gy_reg * ny_reg;
    assign psq_next  = SW'(spd_reg) * SW'(spd_reg);

    always_ff @(posedge clk) begin
        if (adv) begin
            gynx_reg <= gynx_next;
            gxny_reg <= gxny_next;
            gxnx_reg <= gxnx_next;
            gyny_reg <= gyny_next;
            psq_reg  <= psq_next;
        end
    end

    // Stage 2: cross and dot terms, degenerate check
    logic signed [CTW-1:0] c_next, t_next, c2_reg, t2_reg;
    logic [SW-1:0]         p2_reg;
    logic                  deg2_reg;

    assign c_next = CTW'(gynx_reg) - CTW'(gxny_reg);
    assign t_next = CTW'(gxnx_reg) + CTW'(gyny_reg);

    always_ff @(posedge clk) begin
        if (adv) begin
            c2_reg   <= c_next;
            t2_reg   <= t_next;
            p2_reg   <= psq_reg;
            deg2_reg <= (psq_reg == '0) || ((gx_reg == '0) && (gy_reg == '0)) ||
                        (c_next == '0);
        end
    end

    // Stage 3: magnitudes and signs
    logic [MAGW-1:0] pm3_reg, cm3_reg, tm3_reg;
    logic            cneg3_reg, tneg3_reg, deg3_reg;

    always_ff @(posedge clk) begin
        if (adv) begin
            pm3_reg   <= MAGW'(p2_reg);
            cm3_reg   <= MAGW'(c2_reg[CTW-1] ? -c2_reg : c2_reg);
            tm3_reg   <= MAGW'(t2_reg[CTW-1] ? -t2_reg : t2_reg);
            cneg3_reg <= c2_reg[CTW-1];
            tneg3_reg <= t2_reg[CTW-1];
            deg3_reg  <= deg2_reg;
        end
    end

    // Stage 4: common bit length
    logic [MAGW-1:0] pm4_reg, cm4_reg, tm4_reg;
    logic [7:0]      len4_reg;
    logic            cneg4_reg, tneg4_reg, deg4_reg;

    always_ff @(posedge clk) begin
        if (adv) begin
            pm4_reg   <= pm3_reg;
            cm4_reg   <= cm3_reg;
            tm4_reg   <= tm3_reg;
            len4_reg  <= blas_pkg::bit_len(128'(pm3_reg | cm3_reg | tm3_reg));
            cneg4_reg <= cneg3_reg;
            tneg4_reg <= tneg3_reg;
            deg4_reg  <= deg3_reg;
        end
    end

    // Stage 5: scale all three terms so the largest has the fit width
    logic [7:0]     fit_sh;
    logic [FIT-1:0] pf_next, cf_next, tf_next;
    logic [FIT-1:0] p5_reg, c5_reg, t5_reg;
    logic           cneg5_reg, tneg5_reg, deg5_reg;

    always_comb begin
        if (len4_reg > 8'(FIT)) begin
            fit_sh  = len4_reg - 8'(FIT);
            pf_next = FIT'(pm4_reg >> fit_sh);
            cf_next = FIT'(cm4_reg >> fit_sh);
            tf_next = FIT'(tm4_reg >> fit_sh);
        end else begin
            fit_sh  = 8'(FIT) - len4_reg;
            pf_next = FIT'(pm4_reg << fit_sh);
            cf_next = FIT'(cm4_reg << fit_sh);
            tf_next = FIT'(tm4_reg << fit_sh);
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            p5_reg    <= pf_next;
            c5_reg    <= cf_next;
            t5_reg    <= tf_next;
            cneg5_reg <= cneg4_reg;
            tneg5_reg <= tneg4_reg;
            deg5_reg  <= deg4_reg;
        end
    end

    // Stage 6: squares and cross product of the scaled terms
    logic [SQW-1:0] pp6_reg, cc6_reg, pt6_reg;
    logic [FIT-1:0] p6_reg, c6_reg;
    logic           cneg6_reg, tneg6_reg, deg6_reg;

    always_ff @(posedge clk) begin
        if (adv) begin
            pp6_reg   <= SQW'(p5_reg) * SQW'(p5_reg);
            cc6_reg   <= SQW'(c5_reg) * SQW'(c5_reg);
            pt6_reg   <= SQW'(p5_reg) * SQW'(t5_reg);
            p6_reg    <= p5_reg;
            c6_reg    <= c5_reg;
            cneg6_reg <= cneg5_reg;
            tneg6_reg <= tneg5_reg;
            deg6_reg  <= deg5_reg;
        end
    end

    // Stage 7: discriminant
    logic signed [63:0]       two_pt;
    logic signed [63:0]       d_sum;
    logic [blas_pkg::DW-1:0]  d7_reg;
    blas_pkg::side_t          side_d_reg;

    assign two_pt = $signed({3'b000, pt6_reg, 1'b0});
    assign d_sum  = $signed({4'b0000, pp6_reg}) - $signed({4'b0000, cc6_reg}) +
                    (tneg6_reg ? -two_pt : two_pt);

    always_ff @(posedge clk) begin
        if (adv) begin
            d7_reg          <= d_sum[blas_pkg::DW-1:0];
            side_d_reg.p    <= p6_reg;
            side_d_reg.c    <= c6_reg;
            side_d_reg.cneg <= cneg6_reg;
            side_d_reg.deg  <= deg6_reg;
            side_d_reg.kill <= d_sum[63];
            side_d_reg.tang <= (d_sum == 64'sd0);
        end
    end

    // Side line alongside the square root and angle lanes
    blas_pkg::side_t side_reg [SIDE_N];

    for (genvar j = 0; j < SIDE_N; j++) begin : g_side
        if (j == 0) begin : g_first
            always_ff @(posedge clk) begin
                if (adv) side_reg[j] <= side_d_reg;
            end
        end else begin : g_next
            always_ff @(posedge clk) begin
                if (adv) side_reg[j] <= side_reg[j-1];
            end
        end
    end

    // Square root of the discriminant
    logic [31:0] sq_r;

    blas_isqrt u_isqrt (
        .clk   (clk),
        .en    (adv),
        .d_in  (d7_reg),
        .r_out (sq_r)
    );

    // Stage Y: the two root vectors and the gravity vector
    logic signed [CIN_W-1:0] base_s, r_s;
    logic signed [CIN_W-1:0] xr_reg, y1_reg, y2_reg, gxd_reg, gyd_reg;
    blas_pkg::side_t         side_q;

    assign side_q = side_reg[ISQ_N-1];
    assign r_s    = CIN_W'($signed({1'b0, sq_r}));
    assign base_s = side_q.cneg ? CIN_W'($signed({1'b0, side_q.p}))
                                : -CIN_W'($signed({1'b0, side_q.p}));

    always_ff @(posedge clk) begin
        if (adv) begin
            xr_reg  <= CIN_W'($signed({1'b0, side_q.c}));
            y1_reg  <= base_s + r_s;
            y2_reg  <= base_s - r_s;
            gxd_reg <= CIN_W'(gx_reg);
            gyd_reg <= CIN_W'(gy_reg);
        end
    end

    // Three angle lanes
    logic signed [blas_pkg::ZW-1:0] z_dir, z_first, z_second;

    blas_cordic #(.IN_W(CIN_W)) u_cordic_dir (
        .clk   (clk),
        .en    (adv),
        .x_in  (gxd_reg),
        .y_in  (gyd_reg),
        .z_out (z_dir)
    );

    blas_cordic #(.IN_W(CIN_W)) u_cordic_first (
        .clk   (clk),
        .en    (adv),
        .x_in  (xr_reg),
        .y_in  (y1_reg),
        .z_out (z_first)
    );

    blas_cordic #(.IN_W(CIN_W)) u_cordic_second (
        .clk   (clk),
        .en    (adv),
        .x_in  (xr_reg),
        .y_in  (y2_reg),
        .z_out (z_second)
    );

    // Sum stage: add the direction to each root angle
    blas_pkg::side_t      side_z;
    logic signed [AW-1:0] a1_reg, a2_reg, off_reg;
    logic                 blank_reg, degs_reg, tangs_reg;

    assign side_z = side_reg[SIDE_N-1];

    always_ff @(posedge clk) begin
        if (adv) begin
            a1_reg    <= AW'(z_dir) + AW'(z_first);
            a2_reg    <= AW'(z_dir) + AW'(z_second);
            off_reg   <= side_z.cneg ? OFF_POS : OFF_NEG;
            blank_reg <= side_z.deg || side_z.kill;
            degs_reg  <= side_z.deg;
            tangs_reg <= side_z.tang;
        end
    end

    // Output stage: round half up, saturate, blank unsolved beats
    logic signed [AW-1:0]    t1, t2, q1, q2;
    logic signed [ANG_W-1:0] ang1_next, ang2_next;
    logic [1:0]              cnt_next;

    always_comb begin
        t1 = (a1_reg + off_reg + HALF_RND) >>> RS;
        t2 = (a2_reg + off_reg + HALF_RND) >>> RS;
        q1 = (t1 > ANG_LIM) ? ANG_LIM : ((t1 < -ANG_LIM) ? -ANG_LIM : t1);
        q2 = (t2 > ANG_LIM) ? ANG_LIM : ((t2 < -ANG_LIM) ? -ANG_LIM : t2);
        if (blank_reg) begin
            ang1_next = '0;
            ang2_next = '0;
            cnt_next  = 2'd0;
        end else begin
            ang1_next = q1[ANG_W-1:0];
            ang2_next = q2[ANG_W-1:0];
            cnt_next  = tangs_reg ? 2'd1 : 2'd2;
        end
    end

    logic [1:0]              cnt_reg;
    logic signed [ANG_W-1:0] ang1_reg, ang2_reg;
    logic                    deg_reg;

    always_ff @(posedge clk) begin
        if (adv) begin
            cnt_reg  <= cnt_next;
            ang1_reg <= ang1_next;
            ang2_reg <= ang2_next;
            deg_reg  <= degs_reg;
        end
    end

    // Skid register: catch the last stage when the output stalls
    logic                    skid_full_reg;
    logic [1:0]              skid_cnt_reg;
    logic signed [ANG_W-1:0] skid_ang1_reg, skid_ang2_reg;
    logic                    skid_deg_reg;
    logic                    skid_load;

    assign skid_load = !skid_full_reg && v_reg[NS-1] && !out_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            skid_full_reg <= 1'b0;
        end else if (skid_load) begin
            skid_full_reg <= 1'b1;
        end else if (out_ready) begin
            skid_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (skid_load) begin
            skid_cnt_reg  <= cnt_reg;
            skid_ang1_reg <= ang1_reg;
            skid_ang2_reg <= ang2_reg;
            skid_deg_reg  <= deg_reg;
        end
    end

    assign adv            = !skid_full_reg;
    assign in_ready       = adv;
    assign out_valid      = skid_full_reg || v_reg[NS-1];
    assign solution_count = skid_full_reg ? skid_cnt_reg  : cnt_reg;
    assign angle_first    = skid_full_reg ? skid_ang1_reg : ang1_reg;
    assign angle_second   = skid_full_reg ? skid_ang2_reg : ang2_reg;
    assign degenerate     = skid_full_reg ? skid_deg_reg  : deg_reg;

    // Checks
    `BLAS_ASSERT_IMP(a_count_code, out_valid, solution_count != 2'd3)
    `BLAS_ASSERT_IMP(a_degenerate_blank, out_valid && degenerate,
        (solution_count == 2'd0) && (angle_first == '0) && (angle_second == '0))
    `BLAS_ASSERT_IMP(a_stall_has_result, !in_ready, out_valid)
    `BLAS_ASSERT_NXT(a_skid_catches, skid_load, skid_full_reg && out_valid)

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the ballistic launch angle solver.
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        logic [1:0]  count;
        logic [19:0] first;
        logic [19:0] second;
        logic        deg;
    } shot_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [0:0] cfg_index;
    logic [31:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic signed [31:0] source_x, source_y, target_x, target_y;
    logic [30:0] launch_speed;
    logic out_valid;
    logic out_ready;
    logic [1:0] solution_count;
    logic signed [19:0] angle_first, angle_second;
    logic degenerate;

    // Model copy of the gravity registers
    logic signed [31:0] grav_x, grav_y;

    shot_t pending_shots[$];
    int errors;
    int shots_sent;
    int shots_checked;
    int solved_shots;
    int degenerate_shots;
    longint cycles;
    bit calm;

    ballistic_launch_angle_solver uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .source_x(source_x), .source_y(source_y),
        .target_x(target_x), .target_y(target_y), .launch_speed(launch_speed),
        .out_valid(out_valid), .out_ready(out_ready),
        .solution_count(solution_count), .angle_first(angle_first),
        .angle_second(angle_second), .degenerate(degenerate)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Bit length of a non-negative wide value
    function automatic int width_of(logic [127:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 128; i++)
        begin
            if (v[i])
                n = i + 1;
        end
        return n;
    endfunction

    function automatic logic [127:0] magnitude(logic signed [127:0] v);
        return v < 0 ? -v : v;
    endfunction

    // Scale a wide value by 2^-sh, truncating the magnitude
    function automatic longint fit_word(logic signed [127:0] v, int sh);
        logic [127:0] m;
        m = magnitude(v);
        if (sh >= 0)
            m = m >> sh;
        else
            m = m << (-sh);
        return v < 0 ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned r, bt;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > v)
            bt = bt >> 2;
        while (bt != 0)
        begin
            if (v >= r + bt)
            begin
                v = v - (r + bt);
                r = (r >> 1) + bt;
            end
            else
                r = r >> 1;
            bt = bt >> 2;
        end
        return longint'(r);
    endfunction

    // Vectoring rotation: atan2(y, x) in Q30 radians
    function automatic longint atan_q30(longint x, longint y);
        longint base, z, mx, my, dx, dy;
        int k;
        base = 0;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            base = (y >= 0) ? longint'(blas_pkg::PI_Q30) : -longint'(blas_pkg::PI_Q30);
            x = -x;
            y = -y;
        end
        mx = x < 0 ? -x : x;
        my = y < 0 ? -y : y;
        if (my > mx)
            mx = my;
        k = 59 - width_of(128'(mx));
        x = (x < 0) ? -(((-x) << k)) : (x << k);
        y = (y < 0) ? -(((-y) << k)) : (y << k);
        for (int i = 0; i < blas_pkg::CORDIC_ITERS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(blas_pkg::ATAN_TAB[i]);
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(blas_pkg::ATAN_TAB[i]);
            end
        end
        return base + z;
    endfunction

    // Round Q30 to Q16 half up and saturate to +/- 2 pi
    function automatic logic [19:0] angle_word(longint q);
        longint v, lim;
        lim = (longint'(blas_pkg::TWO_PI_Q30) + 8192) >>> 14;
        v = (q + 8192) >>> 14;
        if (v > lim)
            v = lim;
        if (v < -lim)
            v = -lim;
        return v[19:0];
    endfunction

    // Launch angles for one shot under the current gravity
    function automatic shot_t solve_shot(logic signed [31:0] sx, logic signed [31:0] sy,
                                         logic signed [31:0] tx, logic signed [31:0] ty,
                                         logic [30:0] spd);
        shot_t res;
        logic signed [127:0] gx, gy, nx, ny, sp, tmp, pw, cw, tw;
        int bits, sh;
        longint p, c, t, d, r, base, dir;
        bit cneg;
        res = '{count: 2'd0, first: '0, second: '0, deg: 1'b0};
        gx = 128'(grav_x);
        gy = 128'(grav_y);
        nx = 128'(tx);
        tmp = 128'(sx);
        nx = nx - tmp;
        ny = 128'(ty);
        tmp = 128'(sy);
        ny = ny - tmp;
        sp = {97'd0, spd};
        pw = sp * sp;
        cw = gy * nx - gx * ny;
        tw = gx * nx + gy * ny;
        if (spd == 0 || (grav_x == 0 && grav_y == 0) || cw == 0)
        begin
            res.deg = 1'b1;
            return res;
        end
        bits = width_of(magnitude(pw));
        if (width_of(magnitude(cw)) > bits)
            bits = width_of(magnitude(cw));
        if (width_of(magnitude(tw)) > bits)
            bits = width_of(magnitude(tw));
        sh = bits - blas_pkg::FIT_BITS;
        p = fit_word(pw, sh);
        c = fit_word(cw, sh);
        t = fit_word(tw, sh);
        d = p * p - c * c + 2 * p * t;
        if (d < 0)
            return res;
        cneg = cw < 0;
        r = floor_sqrt(d);
        base = cneg ? p : -p;
        if (c < 0)
            c = -c;
        dir = atan_q30(longint'(grav_x), longint'(grav_y))
              - longint'(blas_pkg::HALF_PI_Q30)
              + (cneg ? longint'(blas_pkg::PI_Q30) : 0);
        res.count = (d == 0) ? 2'd1 : 2'd2;
        res.first = angle_word(dir + atan_q30(c, base + r));
        res.second = angle_word(dir + atan_q30(c, base - r));
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    endtask

    // Offer one shot and hold it until the beat is taken
    task automatic send_shot(logic signed [31:0] sx, logic signed [31:0] sy,
                             logic signed [31:0] tx, logic signed [31:0] ty,
                             logic [30:0] spd);
        int gap;
        shot_t want;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        want = solve_shot(sx, sy, tx, ty, spd);
        in_valid <= 1'b1;
        source_x <= sx;
        source_y <= sy;
        target_x <= tx;
        target_y <= ty;
        launch_speed <= spd;
        do
            @(posedge clk);
        while (!in_ready);
        pending_shots.push_back(want);
        shots_sent++;
    endtask

    task automatic drain_shots();
        in_valid <= 1'b0;
        while (pending_shots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write both gravity registers while the pipeline is empty
    task automatic set_gravity(logic signed [31:0] gx, logic signed [31:0] gy);
        drain_shots();
        cfg_write <= 1'b1;
        cfg_index <= blas_pkg::REG_GRAVITY_X;
        cfg_data <= gx;
        @(posedge clk);
        cfg_index <= blas_pkg::REG_GRAVITY_Y;
        cfg_data <= gy;
        @(posedge clk);
        cfg_write <= 1'b0;
        grav_x = gx;
        grav_y = gy;
    endtask

    task automatic test_degenerate();
        // zero speed, coincident points, offset along gravity, zero gravity
        send_shot(0, 0, 32'sd65536, 0, 31'd0);
        send_shot(32'sd12345, -32'sd777, 32'sd12345, -32'sd777, 31'd65536);
        send_shot(0, 0, 32'sd131072, 32'sd131072, 31'd65536);
        set_gravity(0, 0);
        send_shot(0, 0, 32'sd65536, 32'sd65536, 31'd65536);
    endtask

    task automatic test_tangent_and_miss();
        set_gravity(0, 32'sd65536);
        // exactly grazing, far out of reach, comfortably in reach
        send_shot(0, 0, 32'sd1, 0, 31'd256);
        send_shot(0, 0, 32'sd100000000, 0, 31'd1);
        send_shot(0, 0, 32'sd65536, 0, 31'd655360);
        send_shot(0, 0, -32'sd65536, 32'sd65536, 31'd131072);
        set_gravity(0, -32'sd65536);
        send_shot(0, 0, 32'sd196608, -32'sd65536, 31'd200000);
        send_shot(32'sd65536, 0, 0, 0, 31'd300000);
    endtask

    task automatic test_extremes();
        set_gravity(32'h8000_0000, 32'h7fff_ffff);
        send_shot(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
        send_shot(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff);
        send_shot(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 31'd1);
        send_shot(0, 0, 32'sd1, -32'sd1, 31'h7fff_ffff);
        set_gravity(32'h7fff_ffff, 32'h8000_0000);
        send_shot(32'hffff_ffff, 0, 0, 32'hffff_ffff, 31'h4000_0000);
        send_shot(32'h8000_0000, 0, 32'h7fff_ffff, 0, 31'h7fff_ffff);
    endtask

    task automatic test_random(int n);
        logic signed [31:0] sx, sy, tx, ty;
        logic [30:0] spd;
        int mode;
        for (int i = 0; i < n; i++)
        begin
            if (i % 50 == 0)
                calm = ($urandom_range(0, 3) == 0);
            mode = $urandom_range(0, 9);
            sx = $urandom;
            sy = $urandom;
            tx = $urandom;
            ty = $urandom;
            spd = 31'($urandom);
            if (mode < 6)
            begin
                // modest range so both hits and misses occur
                sx = $signed($urandom_range(0, 32'h3f_ffff)) - 32'sh20_0000;
                sy = $signed($urandom_range(0, 32'h3f_ffff)) - 32'sh20_0000;
                tx = $signed($urandom_range(0, 32'h3f_ffff)) - 32'sh20_0000;
                ty = $signed($urandom_range(0, 32'h3f_ffff)) - 32'sh20_0000;
                spd = 31'($urandom_range(0, 32'h0fff_ffff) >> $urandom_range(0, 16));
            end
            else if (mode == 6)
            begin
                tx = sx;
                ty = sy;
            end
            send_shot(sx, sy, tx, ty, spd);
        end
        calm = 1'b0;
    endtask

    // Check each result beat and toggle the downstream stall
    always @(posedge clk)
    begin
        shot_t want;
        int roll;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_shots.size() == 0)
            begin
                errors++;
                $display("unexpected result beat at cycle %0d", cycles);
            end
            else
            begin
                want = pending_shots.pop_front();
                shots_checked++;
                if (want.count != 0)
                    solved_shots++;
                if (want.deg)
                    degenerate_shots++;
                if (solution_count !== want.count)
                    report_mismatch("solution_count", solution_count, want.count);
                if (angle_first !== want.first)
                    report_mismatch("angle_first", $signed(angle_first), $signed(want.first));
                if (angle_second !== want.second)
                    report_mismatch("angle_second", $signed(angle_second),
                                    $signed(want.second));
                if (degenerate !== want.deg)
                    report_mismatch("degenerate", degenerate, want.deg);
            end
        end
        roll = $urandom_range(0, 99);
        if (calm)
            out_ready <= 1'b1;
        else if (roll < 70)
            out_ready <= 1'b1;
        else if (roll < 97)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 1) == 0);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", pending_shots.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = blas_pkg::REG_GRAVITY_X;
        cfg_data = '0;
        in_valid = 1'b0;
        source_x = '0;
        source_y = '0;
        target_x = '0;
        target_y = '0;
        launch_speed = '0;
        out_ready = 1'b0;
        errors = 0;
        shots_sent = 0;
        shots_checked = 0;
        solved_shots = 0;
        degenerate_shots = 0;
        cycles = 0;
        calm = 1'b0;
        grav_x = 32'sd65536;
        grav_y = 32'sd65536;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_random(150);
        test_degenerate();
        test_tangent_and_miss();
        test_extremes();
        test_random(200);
        set_gravity(0, -32'sd65536);
        test_random(200);
        set_gravity(32'sd40000, 32'sd5);
        test_random(150);
        set_gravity(32'h7fff_ffff, 32'h7fff_ffff);
        test_random(100);
        set_gravity($urandom, $urandom);
        test_random(200);
        drain_shots();

        $display("covered %0d shots over several gravity settings: %0d with solutions,",
                 shots_checked, solved_shots);
        $display("%0d degenerate, %0d mismatches", degenerate_shots, errors);
        if (errors == 0 && pending_shots.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/blas_pkg.sv
sv/blas_isqrt.sv
sv/blas_cordic.sv
sv/ballistic_launch_angle_solver.sv
sim/testbench.sv
